// ----- rtl/csms_pkg.sv -----
package csms_pkg;

    localparam int STORE_DEPTH = 8;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [2:0] REG_START_DELAY   = 3'd0;
    localparam logic [2:0] REG_COARSE_COUNT  = 3'd1;
    localparam logic [2:0] REG_FINE_COUNT    = 3'd2;
    localparam logic [2:0] REG_FINE_SPACING  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;
    localparam logic [2:0] REG_INTERVAL_WORD = 3'd5;
    localparam logic [2:0] REG_LISTEN_PORT   = 3'd6;

    localparam logic [15:0] RST_START_DELAY   = 16'd500;
    localparam logic [2:0]  RST_COARSE_COUNT  = 3'd2;
    localparam logic [2:0]  RST_FINE_COUNT    = 3'd5;
    localparam logic [7:0]  RST_FINE_SPACING  = 8'd50;
    localparam logic [7:0]  RST_TIMEOUT_TICKS = 8'd4;
    localparam logic [15:0] RST_INTERVAL_WORD = 16'd156;
    localparam logic [15:0] RST_LISTEN_PORT   = 16'd1234;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MSG  = 1'b1;

    localparam logic [7:0] MSG_DELAY_REQ  = 8'h12;
    localparam int         MSG_RESUME_BIT = 7;
    localparam logic [7:0] MSG_RESTART    = 8'h66;
    localparam logic [7:0] MSG_FINISH     = 8'h77;

    localparam logic [3:0] HDR_INTERVAL   = 4'd1;
    localparam logic [3:0] HDR_DELAY_RESP = 4'd3;
    localparam logic [3:0] HDR_FINE_BASE  = 4'd4;

    typedef struct packed {
        logic [15:0] start_delay;
        logic [2:0]  coarse_count;
        logic [2:0]  fine_count;
        logic [7:0]  fine_spacing;
        logic [7:0]  timeout_ticks;
        logic [15:0] interval_word;
        logic [15:0] listen_port;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [31:0] stamp_low;
        logic [31:0] stamp_high;
        logic [7:0]  message_byte;
        logic [15:0] source_port;
    } t_in_item;

    typedef struct packed {
        logic        emit;
        logic        use_mem;
        logic [3:0]  header;
        logic [15:0] interval;
        logic [63:0] stamp;
    } t_issue;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [63:0]      wdata;
    } t_store_req;

endpackage

// ----- rtl/csms_if.sv -----
interface csms_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] stamp_low;
    logic [31:0] stamp_high;
    logic [7:0]  message_byte;
    logic [15:0] source_port;

    modport source (output valid, command, stamp_low, stamp_high, message_byte,
                    source_port, input ready);
    modport sink (input valid, command, stamp_low, stamp_high, message_byte,
                  source_port, output ready);
endinterface

interface csms_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_stamp_low;
    logic [31:0] out_stamp_high;
    logic [3:0]  header;
    logic [15:0] interval_out;

    modport source (output valid, out_stamp_low, out_stamp_high, header,
                    interval_out, input ready);
    modport sink (input valid, out_stamp_low, out_stamp_high, header,
                  interval_out, output ready);
endinterface

// ----- rtl/csms_regs.sv -----
module csms_regs
    import csms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_START_DELAY:   n_cfg.start_delay   = pwdata[15:0];
                REG_COARSE_COUNT:  n_cfg.coarse_count  = pwdata[2:0];
                REG_FINE_COUNT:    n_cfg.fine_count    = pwdata[2:0];
                REG_FINE_SPACING:  n_cfg.fine_spacing  = pwdata[7:0];
                REG_TIMEOUT_TICKS: n_cfg.timeout_ticks = pwdata[7:0];
                REG_INTERVAL_WORD: n_cfg.interval_word = pwdata[15:0];
                REG_LISTEN_PORT:   n_cfg.listen_port   = pwdata[15:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_DELAY:   prdata = {16'd0, r_cfg.start_delay};
            REG_COARSE_COUNT:  prdata = {29'd0, r_cfg.coarse_count};
            REG_FINE_COUNT:    prdata = {29'd0, r_cfg.fine_count};
            REG_FINE_SPACING:  prdata = {24'd0, r_cfg.fine_spacing};
            REG_TIMEOUT_TICKS: prdata = {24'd0, r_cfg.timeout_ticks};
            REG_INTERVAL_WORD: prdata = {16'd0, r_cfg.interval_word};
            REG_LISTEN_PORT:   prdata = {16'd0, r_cfg.listen_port};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay   <= RST_START_DELAY;
            r_cfg.coarse_count  <= RST_COARSE_COUNT;
            r_cfg.fine_count    <= RST_FINE_COUNT;
            r_cfg.fine_spacing  <= RST_FINE_SPACING;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
            r_cfg.interval_word <= RST_INTERVAL_WORD;
            r_cfg.listen_port   <= RST_LISTEN_PORT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

`ifndef ASSERT_OFF
    a_coarse_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && reg_idx == REG_COARSE_COUNT |=> r_cfg.coarse_count == $past(pwdata[2:0]))
        else $error("coarse_count write lost");
`endif

endmodule

// ----- rtl/csms_store.sv -----
module csms_store
    import csms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_req  i_req,
    output logic [63:0] o_rd_data
);

    logic [63:0]            r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [63:0]            r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_valid <= r_valid[i_req.raddr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : 64'd0;

`ifndef ASSERT_OFF
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.re && i_req.we && i_req.raddr == i_req.waddr))
        else $error("store read and write hit the same entry");
`endif

endmodule

// ----- rtl/csms_seq.sv -----
module csms_seq
    import csms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    output t_issue     o_issue,
    output t_store_req o_store
);

    logic [15:0]      r_tc, n_tc;
    logic             r_coarse, n_coarse;
    logic             r_fine, n_fine;
    logic [2:0]       r_ci, n_ci;
    logic [IDX_W-1:0] r_fi, n_fi;
    logic [7:0]       r_sc, n_sc;
    logic             r_wt, n_wt;
    logic [7:0]       r_toc, n_toc;

    logic [63:0] stamp;
    logic [15:0] reload;
    logic        port_hit;

    assign stamp    = {i_item.stamp_high, i_item.stamp_low};
    assign reload   = i_cfg.start_delay - 16'd1;
    assign port_hit = i_item.source_port == i_cfg.listen_port;

    always_comb begin
        n_tc     = r_tc;
        n_coarse = r_coarse;
        n_fine   = r_fine;
        n_ci     = r_ci;
        n_fi     = r_fi;
        n_sc     = r_sc;
        n_wt     = r_wt;
        n_toc    = r_toc;
        o_issue  = '0;
        o_store  = '0;
        o_issue.stamp = stamp;

        if (i_item.command == CMD_TICK) begin
            n_tc = r_tc + 16'd1;
            if (n_tc > i_cfg.start_delay) begin
                if (r_coarse) begin
                    n_ci = r_ci + 3'd1;
                    o_issue.emit   = 1'b1;
                    o_issue.header = {1'b0, n_ci};
                    if (n_ci == i_cfg.coarse_count) begin
                        n_coarse = 1'b0;
                        n_ci     = 3'd0;
                        n_wt     = 1'b1;
                        n_toc    = 8'd0;
                    end
                end else if (r_fine) begin
                    if (r_sc == 8'd0) begin
                        o_issue.emit    = 1'b1;
                        o_issue.use_mem = 1'b1;
                        o_issue.header  = {1'b0, r_fi} + HDR_FINE_BASE;
                        o_store.re      = 1'b1;
                        o_store.raddr   = r_fi;
                        n_fi            = r_fi + 3'd1;
                        o_store.we      = 1'b1;
                        o_store.waddr   = n_fi;
                        o_store.wdata   = stamp;
                        n_sc = (n_fi != i_cfg.fine_count - 3'd1) ? i_cfg.fine_spacing : 8'd1;
                    end
                    n_sc = n_sc - 8'd1;
                    if (n_fi == i_cfg.fine_count) begin
                        n_wt = 1'b1;
                    end
                end
            end
            if (n_wt) begin
                n_toc = n_toc + 8'd1;
                if (n_toc == i_cfg.timeout_ticks) begin
                    if (r_fine) begin
                        n_coarse = 1'b0;
                        n_fi     = n_fi - 3'd1;
                    end else begin
                        n_coarse = 1'b1;
                    end
                    n_toc = 8'd0;
                    n_wt  = 1'b0;
                    n_ci  = 3'd0;
                    n_tc  = reload;
                    n_sc  = 8'd0;
                end
            end
        end else if (port_hit) begin
            if (i_item.message_byte == MSG_DELAY_REQ) begin
                o_issue.emit   = 1'b1;
                o_issue.header = HDR_DELAY_RESP;
                n_coarse = 1'b0;
                n_fine   = 1'b1;
                n_sc     = 8'd0;
                n_fi     = 3'd0;
                n_wt     = 1'b0;
                n_toc    = 8'd0;
            end else if (i_item.message_byte[MSG_RESUME_BIT]) begin
                n_fi     = i_item.message_byte[2:0] - 3'd4;
                n_coarse = 1'b0;
                n_fine   = 1'b1;
                n_tc     = reload;
                n_sc     = 8'd0;
                n_wt     = 1'b0;
                n_toc    = 8'd0;
            end else if (i_item.message_byte == MSG_RESTART) begin
                n_coarse = 1'b1;
                n_ci     = 3'd0;
                n_fine   = 1'b0;
                n_fi     = 3'd0;
                n_tc     = reload;
                n_wt     = 1'b0;
                n_toc    = 8'd0;
            end else if (i_item.message_byte == MSG_FINISH) begin
                n_fine   = 1'b0;
                n_fi     = 3'd0;
                n_tc     = 16'd0;
                n_coarse = 1'b1;
                n_sc     = 8'd0;
                n_wt     = 1'b0;
                n_toc    = 8'd0;
            end
        end

        o_issue.interval = (o_issue.header == HDR_INTERVAL) ? i_cfg.interval_word : 16'd0;
        if (!i_accept) begin
            o_issue.emit = 1'b0;
            o_store.re   = 1'b0;
            o_store.we   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc     <= 16'd0;
            r_coarse <= 1'b1;
            r_fine   <= 1'b0;
            r_ci     <= 3'd0;
            r_fi     <= '0;
            r_sc     <= 8'd0;
            r_wt     <= 1'b0;
            r_toc    <= 8'd0;
        end else if (i_accept) begin
            r_tc     <= n_tc;
            r_coarse <= n_coarse;
            r_fine   <= n_fine;
            r_ci     <= n_ci;
            r_fi     <= n_fi;
            r_sc     <= n_sc;
            r_wt     <= n_wt;
            r_toc    <= n_toc;
        end
    end

`ifndef ASSERT_OFF
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_coarse && r_fine))
        else $error("coarse and fine phases both active");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.command == CMD_MSG && port_hit
        && i_item.message_byte == MSG_FINISH |=> r_tc == 16'd0 && r_coarse && !r_fine)
        else $error("finish message did not restart coarse phase");
`endif

endmodule

// ----- rtl/csms_pipe.sv -----
module csms_pipe
    import csms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_issue      i_issue,
    input  logic [63:0] i_rd_data,
    output logic        o_ready,
    csms_out_if.source  o_out
);

    logic        r_s1_valid;
    logic        r_s1_use_mem;
    logic [3:0]  r_s1_header;
    logic [15:0] r_s1_interval;
    logic [63:0] r_s1_stamp;

    logic        r_s2_valid;
    logic [3:0]  r_s2_header;
    logic [15:0] r_s2_interval;
    logic [63:0] r_s2_stamp;

    logic        s1_move;
    logic        s1_load;
    logic [63:0] s1_stamp;

    assign s1_move  = r_s1_valid && (!r_s2_valid || o_out.ready);
    assign o_ready  = !r_s1_valid || s1_move;
    assign s1_load  = i_accept && i_issue.emit;
    assign s1_stamp = r_s1_use_mem ? i_rd_data : r_s1_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_use_mem  <= i_issue.use_mem;
            r_s1_header   <= i_issue.header;
            r_s1_interval <= i_issue.interval;
            r_s1_stamp    <= i_issue.stamp;
        end
        if (s1_move) begin
            r_s2_header   <= r_s1_header;
            r_s2_interval <= r_s1_interval;
            r_s2_stamp    <= s1_stamp;
        end
    end

    assign o_out.valid          = r_s2_valid;
    assign o_out.out_stamp_low  = r_s2_stamp[31:0];
    assign o_out.out_stamp_high = r_s2_stamp[63:32];
    assign o_out.header         = r_s2_header;
    assign o_out.interval_out   = r_s2_interval;

`ifndef ASSERT_OFF
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load |=> r_s1_valid)
        else $error("emitted transfer not captured");
`endif

endmodule

// ----- rtl/clock_sync_master_sequencer_core.sv -----
// Clock-sync master sequencer.
// Input channel i_in: one transfer per tick (command 0, stamp = latest
// transmit timestamp) or per received message (command 1, with first
// payload byte, source port and receive timestamp).
// Output channel o_out: packets to send (timestamp, header, interval word);
// an input produces zero or one packet.
// Registers are written over the APB port (register i at byte 4*i); the
// user must write them only while the block is idle, which the block does
// not enforce. Unknown addresses are ignored and read as zero. A packet
// passes registered result stages s1 and s2 before it reaches o_out.
// Throughput: one input per cycle while o_out does not stall; state updates
// complete at the accept edge, where the fine-phase timestamp store is also
// read through a registered memory port. When o_out stalls, the two result
// stages fill and i_in.ready drops; inputs that produce no packet are still
// taken while a stage is free. Reset: coarse phase active, counters and
// index zero, registers at defaults, store reads zero until written.
module clock_sync_master_sequencer_core
    import csms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    csms_in_if.sink     i_in,
    csms_out_if.source  o_out
);

    t_cfg       cfg;
    t_in_item   item;
    t_issue     issue;
    t_store_req store_req;
    logic [63:0] rd_data;
    logic       in_ready;
    logic       accept;

    assign item.command      = i_in.command;
    assign item.stamp_low    = i_in.stamp_low;
    assign item.stamp_high   = i_in.stamp_high;
    assign item.message_byte = i_in.message_byte;
    assign item.source_port  = i_in.source_port;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    csms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csms_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_issue  (issue),
        .o_store  (store_req)
    );

    csms_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    csms_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_issue   (issue),
        .i_rd_data (rd_data),
        .o_ready   (in_ready),
        .o_out     (o_out)
    );

endmodule
